// ===== rtl/tvce_pkg.sv =====
// Shared types, constants and tables of the turtle vector command engine.
`timescale 1ns / 1ps
package tvce_pkg;

  localparam int unsigned StackDepthDefault = 64;
  localparam int unsigned CordicSteps = 20;

  localparam logic [24:0] FullTurn    = 25'd23592960;
  localparam logic [24:0] QuarterTurn = 25'd5898240;
  localparam logic [31:0] CordicStart = 32'd652032874;

  localparam logic [7:0] SymFwdLine = 8'h46;  // F
  localparam logic [7:0] SymFwdMove = 8'h66;  // f
  localparam logic [7:0] SymBckLine = 8'h42;  // B
  localparam logic [7:0] SymBckMove = 8'h62;  // b
  localparam logic [7:0] SymTurnR   = 8'h2B;  // +
  localparam logic [7:0] SymTurnL   = 8'h2D;  // -
  localparam logic [7:0] SymPush    = 8'h5B;  // [
  localparam logic [7:0] SymPop     = 8'h5D;  // ]
  localparam logic [7:0] SymMul     = 8'h4D;  // M
  localparam logic [7:0] SymDiv     = 8'h44;  // D

  localparam logic [2:0] RegAngleStep   = 3'd0;
  localparam logic [2:0] RegScaleFactor = 3'd1;
  localparam logic [2:0] RegInitialStep = 3'd2;
  localparam logic [2:0] RegStartHead   = 3'd3;
  localparam logic [2:0] RegStartX      = 3'd4;
  localparam logic [2:0] RegStartY      = 3'd5;

  localparam logic [1:0] KindMove      = 2'd0;
  localparam logic [1:0] KindLine      = 2'd1;
  localparam logic [1:0] KindOverflow  = 2'd2;
  localparam logic [1:0] KindUnderflow = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DECODE, ST_CORDIC, ST_MULX, ST_MULY, ST_APPLY,
    ST_MUL, ST_DIV, ST_POPRD, ST_POPWR, ST_OUT
  } tvce_state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic       load_item;
    logic       restart;
    logic       turn_r;
    logic       turn_l;
    logic       cordic_init;
    logic       cordic_step;
    logic       mul_x;
    logic       mul_y;
    logic       apply_move;
    logic       back;
    logic       mul_step;
    logic       div_init;
    logic       div_step;
    logic       div_done;
    logic       push;
    logic       pop_rd;
    logic       pop_wr;
    logic       emit;
    logic [1:0] kind;
  } tvce_cmd_t;

  typedef struct packed {
    logic [7:0] symbol;
    logic       restart;
    logic       stack_full;
    logic       stack_empty;
    logic       iter_last;
  } tvce_status_t;

  function automatic logic [28:0] atan_deg(input logic [4:0] i);
    logic [28:0] r;
    unique case (i)
      5'd0: r = 29'd188743680; 5'd1: r = 29'd111421900; 5'd2: r = 29'd58872272;
      5'd3: r = 29'd29884485;  5'd4: r = 29'd15000234;  5'd5: r = 29'd7507429;
      5'd6: r = 29'd3754631;   5'd7: r = 29'd1877430;   5'd8: r = 29'd938729;
      5'd9: r = 29'd469367;    5'd10: r = 29'd234683;   5'd11: r = 29'd117342;
      5'd12: r = 29'd58671;    5'd13: r = 29'd29335;    5'd14: r = 29'd14668;
      5'd15: r = 29'd7334;     5'd16: r = 29'd3667;     5'd17: r = 29'd1833;
      5'd18: r = 29'd917;      5'd19: r = 29'd458;
      default: r = 29'd0;
    endcase
    return r;
  endfunction

  function automatic logic [24:0] reduce_angle(input logic [24:0] a);
    return (a >= FullTurn) ? a - FullTurn : a;
  endfunction

endpackage

// ===== rtl/tvce_ctrl.sv =====
// Controller state machine sequencing each item through the datapath.
`timescale 1ns / 1ps
module tvce_ctrl
  import tvce_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_stall_o,
  output logic         out_valid_o,
  input  logic         out_stall_i,
  input  tvce_status_t status_i,
  output tvce_cmd_t    cmd_o
);

  tvce_state_e state_q, state_d;
  logic [1:0]  kind_q, kind_d;
  logic        back_q, back_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      kind_q  <= KindMove;
      back_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      kind_q  <= kind_d;
      back_q  <= back_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = (state_q == ST_OUT);

  // Next state and commands
  always_comb begin
    state_d = state_q;
    kind_d  = kind_q;
    back_d  = back_q;
    cmd_o   = '0;
    cmd_o.back = back_q;
    cmd_o.kind = kind_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d = ST_DECODE;
        end
      end
      ST_DECODE: begin
        cmd_o.restart = status_i.restart;
        state_d = ST_IDLE;
        unique case (status_i.symbol)
          SymFwdLine, SymFwdMove, SymBckLine, SymBckMove: begin
            kind_d = (status_i.symbol == SymFwdLine || status_i.symbol == SymBckLine)
                     ? KindLine : KindMove;
            back_d = (status_i.symbol == SymBckLine || status_i.symbol == SymBckMove);
            state_d = ST_CORDIC;
          end
          SymTurnR: cmd_o.turn_r = 1'b1;
          SymTurnL: cmd_o.turn_l = 1'b1;
          SymMul: state_d = ST_MUL;
          SymDiv: state_d = ST_DIV;
          SymPush: begin
            if (status_i.stack_full && !status_i.restart) begin
              kind_d = KindOverflow;
              state_d = ST_OUT;
            end else begin
              cmd_o.push = 1'b1;
            end
          end
          SymPop: begin
            if (status_i.stack_empty || status_i.restart) begin
              kind_d = KindUnderflow;
              state_d = ST_OUT;
            end else begin
              state_d = ST_POPRD;
            end
          end
          default: ;
        endcase
        cmd_o.cordic_init = (state_d == ST_CORDIC);
        cmd_o.div_init    = (state_d == ST_DIV);
      end
      ST_CORDIC: begin
        cmd_o.cordic_step = 1'b1;
        if (status_i.iter_last) state_d = ST_MULX;
      end
      ST_MULX: begin
        cmd_o.mul_x = 1'b1;
        state_d = ST_MULY;
      end
      ST_MULY: begin
        cmd_o.mul_y = 1'b1;
        state_d = ST_APPLY;
      end
      ST_APPLY: begin
        cmd_o.apply_move = 1'b1;
        state_d = ST_OUT;
      end
      ST_MUL: begin
        cmd_o.mul_step = 1'b1;
        state_d = ST_IDLE;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.iter_last) begin
          cmd_o.div_done = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_POPRD: begin
        cmd_o.pop_rd = 1'b1;
        state_d = ST_POPWR;
      end
      ST_POPWR: begin
        cmd_o.pop_wr = 1'b1;
        kind_d = KindMove;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        cmd_o.emit = 1'b1;
        if (!out_stall_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> in_stall_o) else $error("accept while busy");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o) else $error("result dropped");
  a_cordic_to_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CORDIC && status_i.iter_last) |=> (state_q == ST_MULX))
    else $error("cordic exit");
`endif

endmodule

// ===== rtl/tvce_datapath.sv =====
// Turtle state, stack memory, CORDIC, multiplier and divider datapath.
`timescale 1ns / 1ps
module tvce_datapath
  import tvce_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = StackDepthDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tvce_cmd_t          cmd_i,
  output tvce_status_t       status_o,
  input  logic [7:0]         symbol_i,
  input  logic               restart_i,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  output logic [1:0]         kind_o,
  output logic signed [15:0] pixel_x_o,
  output logic signed [15:0] pixel_y_o
);

  localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned LW = $clog2(STACK_DEPTH + 1);
  localparam logic [LW-1:0] LevelMax = LW'(STACK_DEPTH);

  // Configuration registers
  logic [24:0] angle_step_q, start_head_q;
  logic [23:0] scale_q;
  logic [31:0] init_step_q, start_x_q, start_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      angle_step_q <= 25'd5898240;
      scale_q      <= 24'd65536;
      init_step_q  <= 32'd655360;
      start_head_q <= '0;
      start_x_q    <= '0;
      start_y_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        RegAngleStep:   angle_step_q <= cfg_data_i[24:0];
        RegScaleFactor: scale_q      <= cfg_data_i[23:0];
        RegInitialStep: init_step_q  <= cfg_data_i;
        RegStartHead:   start_head_q <= cfg_data_i[24:0];
        RegStartX:      start_x_q    <= cfg_data_i;
        RegStartY:      start_y_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [7:0]  sym_q;
  logic        rst_item_q;
  logic signed [31:0] pos_x_q, pos_y_q;
  logic [24:0] head_q;
  logic [31:0] step_q;
  logic [LW-1:0] level_q;

  // CORDIC state
  logic signed [33:0] cx_q, cy_q;
  logic signed [30:0] cz_q;
  logic [1:0]  quad_q;
  logic [4:0]  it_q;
  logic signed [33:0] dx_q, dy_q;

  // Divider state
  logic [47:0] dq_q;
  logic [24:0] drem_q;
  logic [5:0]  dit_q;

  // Stack memory; a push with restart stores the restart state at the bottom
  logic [120:0] stack_mem [STACK_DEPTH];
  logic [120:0] pop_q;
  logic [120:0] push_data;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [LW-1:0] lvl_m1;
  assign lvl_m1    = level_q - LW'(1);
  assign wr_addr   = cmd_i.restart ? '0 : level_q[AW-1:0];
  assign rd_addr   = lvl_m1[AW-1:0];
  assign push_data = cmd_i.restart
                     ? {start_x_q, start_y_q, reduce_angle(start_head_q), init_step_q}
                     : {pos_x_q, pos_y_q, head_q, step_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) stack_mem[wr_addr] <= push_data;
    if (cmd_i.pop_rd) pop_q <= stack_mem[rd_addr];
  end

  // Angle rotation for the current item, after an optional restart
  logic [24:0] head_eff, ang;
  logic [25:0] hsum;
  assign head_eff = cmd_i.restart ? reduce_angle(start_head_q) : head_q;
  assign ang      = reduce_angle(angle_step_q);
  assign hsum     = {1'b0, head_eff} + {1'b0, ang};

  // Quadrant split of the heading
  logic [1:0]  quad;
  logic [24:0] zrem;
  always_comb begin
    if (head_q >= 25'd17694720) begin quad = 2'd3; zrem = head_q - 25'd17694720; end
    else if (head_q >= 25'd11796480) begin quad = 2'd2; zrem = head_q - 25'd11796480; end
    else if (head_q >= QuarterTurn) begin quad = 2'd1; zrem = head_q - QuarterTurn; end
    else begin quad = 2'd0; zrem = head_q; end
  end

  // Quadrant-rotated cos and sin
  logic signed [33:0] tc, ts;
  always_comb begin
    unique case (quad_q)
      2'd0: begin tc = cx_q;  ts = cy_q;  end
      2'd1: begin tc = -cy_q; ts = cx_q;  end
      2'd2: begin tc = -cx_q; ts = -cy_q; end
      default: begin tc = cy_q; ts = -cx_q; end
    endcase
  end

  // Shared multiplier: step times trig magnitude, rounded
  logic signed [33:0] tsel;
  logic [32:0] tmag;
  logic [64:0] prod;
  logic [33:0] pround;
  assign tsel   = cmd_i.mul_x ? tc : ts;
  assign tmag   = tsel[33] ? 33'(-tsel) : tsel[32:0];
  assign prod   = 65'(step_q) * 65'(tmag);
  assign pround = 34'((prod + 65'(1 << 29)) >> 30);

  // Saturating position update
  function automatic logic signed [31:0] sat_add(input logic signed [31:0] p,
                                                  input logic signed [33:0] d);
    logic signed [34:0] s;
    s = 35'(p) + 35'(d);
    if (s > 35'sd2147483647) return 32'sh7FFFFFFF;
    if (s < -35'sd2147483648) return 32'sh80000000;
    return s[31:0];
  endfunction

  logic [55:0] mprod;
  assign mprod = 56'(step_q) * 56'(scale_q);
  logic [25:0] dtrial;
  assign dtrial = {drem_q, dq_q[47]} - {2'b0, scale_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q <= '0;
      pos_y_q <= '0;
      head_q  <= '0;
      step_q  <= 32'd655360;
      level_q <= '0;
    end else begin
      if (cmd_i.restart) begin
        pos_x_q <= start_x_q;
        pos_y_q <= start_y_q;
        head_q  <= reduce_angle(start_head_q);
        step_q  <= init_step_q;
        level_q <= '0;
      end
      if (cmd_i.turn_r)
        head_q <= (head_eff >= ang) ? head_eff - ang : 25'(hsum - {1'b0, ang} - {1'b0, ang}
                  + {1'b0, FullTurn});
      if (cmd_i.turn_l)
        head_q <= (hsum >= {1'b0, FullTurn}) ? 25'(hsum - {1'b0, FullTurn}) : hsum[24:0];
      if (cmd_i.push) level_q <= cmd_i.restart ? LW'(1) : level_q + LW'(1);
      if (cmd_i.apply_move) begin
        pos_x_q <= sat_add(pos_x_q, cmd_i.back ? -dx_q : dx_q);
        pos_y_q <= sat_add(pos_y_q, cmd_i.back ? -dy_q : dy_q);
      end
      if (cmd_i.mul_step)
        step_q <= (|mprod[55:48]) ? 32'hFFFFFFFF : mprod[47:16];
      if (cmd_i.div_done)
        step_q <= (scale_q == '0 || |dq_q[46:31]) ? 32'hFFFFFFFF :
                  {dq_q[30:0], ~dtrial[25]};
      if (cmd_i.pop_wr) begin
        level_q <= lvl_m1;
        pos_x_q <= pop_q[120:89];
        pos_y_q <= pop_q[88:57];
        head_q  <= pop_q[56:32];
        step_q  <= pop_q[31:0];
      end
    end
  end

  // Item, CORDIC, product and divider registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      sym_q      <= symbol_i;
      rst_item_q <= restart_i;
    end
    if (cmd_i.cordic_init) begin
      cx_q <= 34'(CordicStart);
      cy_q <= '0;
      it_q <= '0;
    end else if (cmd_i.cordic_step) begin
      if (it_q == 5'd0) begin
        quad_q <= quad;
        cx_q <= 34'(CordicStart);
        cy_q <= 34'(CordicStart);
        cz_q <= (31'(zrem) <<< 6) - 31'(atan_deg(5'd0));
      end else begin
        if (!cz_q[30]) begin
          cx_q <= cx_q - (cy_q >>> it_q);
          cy_q <= cy_q + (cx_q >>> it_q);
          cz_q <= cz_q - 31'(atan_deg(it_q));
        end else begin
          cx_q <= cx_q + (cy_q >>> it_q);
          cy_q <= cy_q - (cx_q >>> it_q);
          cz_q <= cz_q + 31'(atan_deg(it_q));
        end
      end
      it_q <= it_q + 5'd1;
    end
    if (cmd_i.mul_x) dx_q <= tsel[33] ? -$signed(pround) : $signed(pround);
    if (cmd_i.mul_y) dy_q <= tsel[33] ? -$signed(pround) : $signed(pround);
    if (cmd_i.div_init) begin
      dq_q   <= {cmd_i.restart ? init_step_q : step_q, 16'h0};
      drem_q <= '0;
      dit_q  <= '0;
    end else if (cmd_i.div_step) begin
      if (!dtrial[25]) drem_q <= dtrial[24:0];
      else drem_q <= {drem_q[23:0], dq_q[47]};
      dq_q  <= {dq_q[46:0], ~dtrial[25]};
      dit_q <= dit_q + 6'd1;
    end
  end

  assign status_o.symbol      = sym_q;
  assign status_o.restart     = rst_item_q;
  assign status_o.stack_full  = (level_q >= LevelMax);
  assign status_o.stack_empty = (level_q == '0);
  assign status_o.iter_last   = cmd_i.div_step ? (dit_q == 6'd47) :
                                (it_q == 5'(CordicSteps - 1));

  // Result fields, truncated toward zero
  logic signed [31:0] tx, ty;
  assign tx = pos_x_q + ((pos_x_q[31] && |pos_x_q[15:0]) ? 32'sd65536 : 32'sd0);
  assign ty = pos_y_q + ((pos_y_q[31] && |pos_y_q[15:0]) ? 32'sd65536 : 32'sd0);
  assign kind_o    = cmd_i.kind;
  assign pixel_x_o = tx[31:16];
  assign pixel_y_o = ty[31:16];

`ifndef NO_ASSERTIONS
  a_level_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    level_q <= LevelMax) else $error("stack level out of range");
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.push && !cmd_i.restart) |-> (level_q < LevelMax)) else $error("push when full");
  a_head_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_q < FullTurn) else $error("heading out of range");
`endif

endmodule

// ===== rtl/turtle_vector_command_engine_unit.sv =====
// Top level of the turtle vector command engine.
`timescale 1ns / 1ps
// Takes one turtle symbol per item and emits move_to, line_to or stack
// fault results. A move symbol passes through accept, decode, a 20-step
// CORDIC, two shared multiplies, position update and result; D runs in the
// one-bit-per-cycle divider, and a pop reads the stack before it restores
// the turtle state and emits its result. A stalled result holds until the
// stall drops. One item is in flight at a time. The stack is a
// STACK_DEPTH-entry memory.
module turtle_vector_command_engine_unit
  import tvce_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = StackDepthDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         symbol_i,
  input  logic               restart_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         kind_o,
  output logic signed [15:0] pixel_x_o,
  output logic signed [15:0] pixel_y_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i
);

  tvce_cmd_t    cmd;
  tvce_status_t status;

  assign cfg_ready_o = 1'b1;

  tvce_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .status_i(status), .cmd_o(cmd)
  );

  tvce_datapath #(.STACK_DEPTH(STACK_DEPTH)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .status_o(status), .symbol_i, .restart_i,
    .cfg_we_i(cfg_valid_i), .cfg_index_i, .cfg_data_i,
    .kind_o, .pixel_x_o, .pixel_y_o
  );

endmodule
